FILE: rtl/sslscan_pkg.sv
// Shared types and character codes for the string literal scanner.
`default_nettype none

package sslscan_pkg;

	// Scanner context while walking the source text
	typedef enum logic [2:0] {
		MODE_NORMAL     = 3'd0,
		MODE_SLASH      = 3'd1,
		MODE_LINE       = 3'd2,
		MODE_BLOCK      = 3'd3,
		MODE_BLOCK_STAR = 3'd4,
		MODE_CHAR       = 3'd5,
		MODE_STRING     = 3'd6,
		MODE_ESCAPE     = 3'd7
	} scan_mode_t;

	// Characters the scanner reacts to
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_APOS      = 8'h27;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_STAR      = 8'h2A;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;

	// Remaining bytes to skip in a char literal
	localparam logic [1:0] SKIP_ONE = 2'd1;
	localparam logic [1:0] SKIP_TWO = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/source_string_literal_scanner_top.sv
// An accepted byte is held in the input register, its result word in the output register.
// Throughput: one source byte per cycle unless a result byte meets a stalled full output;
// bytes with no result never wait for the output side.
// The scanner state is updated in the same step as the output word is formed.
// Reset: arst_n clears the scanner state and both valid flags at once; no sweep.
// Bytes after a final byte (tlast) start from the reset state again.
`default_nettype none

module source_string_literal_scanner_top
	import sslscan_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // [7:0] in_byte
	input  wire logic       s_axis_tlast,  // last_byte
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,  // [7:0] out_byte
	output logic            m_axis_tuser,  // byte_valid
	output logic            m_axis_tlast   // literal_end
);

	// Input register
	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Scanner state
	scan_mode_t mode_q;
	logic [1:0] skip_q;
	logic       first_q;

	// Output register
	logic       vld_s2;
	logic [7:0] byte_s2;
	logic       bvld_s2;
	logic       end_s2;

	// Next-state and result of the byte in the input register
	scan_mode_t mode_d;
	scan_mode_t mode_c;
	logic [1:0] skip_d;
	logic [1:0] skip_c;
	logic       first_d;
	logic       first_c;
	logic [7:0] ob_c;
	logic       bvld_c;
	logic       end_c;
	logic       has_res;
	logic       adv;

	// Scanner step
	always_comb begin
		mode_c  = mode_q;
		skip_c  = skip_q;
		first_c = first_q;
		ob_c    = '0;
		bvld_c  = 1'b0;
		end_c   = 1'b0;
		case (mode_q)
			MODE_NORMAL, MODE_SLASH: begin
				if (mode_q == MODE_SLASH && byte_s1 == CH_SLASH) begin
					mode_c = MODE_LINE;
				end else if (mode_q == MODE_SLASH && byte_s1 == CH_STAR) begin
					mode_c = MODE_BLOCK;
				end else if (byte_s1 == CH_QUOTE) begin
					mode_c = MODE_STRING;
				end else if (byte_s1 == CH_SLASH) begin
					mode_c = MODE_SLASH;
				end else if (byte_s1 == CH_APOS) begin
					mode_c  = MODE_CHAR;
					first_c = 1'b1;
					skip_c  = '0;
				end else begin
					mode_c = MODE_NORMAL;
				end
			end
			MODE_LINE: begin
				if (byte_s1 == CH_NEWLINE) mode_c = MODE_NORMAL;
			end
			MODE_BLOCK: begin
				if (byte_s1 == CH_STAR) mode_c = MODE_BLOCK_STAR;
			end
			MODE_BLOCK_STAR: begin
				if (byte_s1 == CH_SLASH) mode_c = MODE_NORMAL;
				else if (byte_s1 != CH_STAR) mode_c = MODE_BLOCK;
			end
			MODE_CHAR: begin
				if (first_q) begin
					first_c = 1'b0;
					skip_c  = (byte_s1 == CH_BACKSLASH) ? SKIP_TWO : SKIP_ONE;
				end else begin
					skip_c = skip_q - 2'd1;
					if (skip_c == 2'd0) mode_c = MODE_NORMAL;
				end
			end
			MODE_STRING: begin
				if (byte_s1 inside {CH_QUOTE, CH_NEWLINE}) begin
					end_c  = 1'b1;
					mode_c = MODE_NORMAL;
				end else begin
					ob_c   = byte_s1;
					bvld_c = 1'b1;
					if (byte_s1 == CH_BACKSLASH) mode_c = MODE_ESCAPE;
				end
			end
			MODE_ESCAPE: begin
				ob_c   = byte_s1;
				bvld_c = 1'b1;
				mode_c = MODE_STRING;
			end
			default: begin
				mode_c = MODE_NORMAL;
			end
		endcase

		// End of text closes an open literal and returns to reset state
		mode_d  = mode_c;
		skip_d  = skip_c;
		first_d = first_c;
		if (last_s1) begin
			if (mode_c inside {MODE_STRING, MODE_ESCAPE}) end_c = 1'b1;
			mode_d  = MODE_NORMAL;
			skip_d  = '0;
			first_d = 1'b0;
		end
	end

	// Handshake: a byte with no result never waits for the output side
	assign has_res       = bvld_c | end_c;
	assign adv           = vld_s1 & (~vld_s2 | m_axis_tready | ~has_res);
	assign s_axis_tready = ~vld_s1 | adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NORMAL;
			skip_q  <= '0;
			first_q <= 1'b0;
		end else if (adv) begin
			mode_q  <= mode_d;
			skip_q  <= skip_d;
			first_q <= first_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv && has_res) begin
			vld_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && has_res) begin
			byte_s2 <= ob_c;
			bvld_s2 <= bvld_c;
			end_s2  <= end_c;
		end
	end

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = byte_s2;
	assign m_axis_tuser  = bvld_s2;
	assign m_axis_tlast  = end_s2;

`ifndef SYNTHESIS
	// Every word presented carries content or an end marker
	a_word_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser || m_axis_tlast))
		else $error("empty result word presented");

	// Marker-only words carry a zero byte
	a_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 8'h00))
		else $error("end marker word with nonzero byte");

	// Inside a char literal past the first byte there is always something left to skip
	a_skip_live: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_CHAR && !first_q) |-> (skip_q != 2'd0))
		else $error("char literal skip count ran out");

	// A final byte leaves the scanner in its reset state
	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> (mode_q == MODE_NORMAL && skip_q == 2'd0 && !first_q))
		else $error("state not cleared after final byte");

	// A byte with a result is held while the output word is stalled
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && has_res && vld_s2 && !m_axis_tready) |=> vld_s1)
		else $error("input byte lost under back-pressure");
`endif

endmodule

`default_nettype wire
